// ----- hw/rtl/bpc_pkg.sv -----
`default_nettype none

package bpc_pkg;

    // field widths
    localparam int TimeW = 32;
    localparam int ThrW  = 16;
    localparam int IdxW  = 2;
    localparam int KindW = 2;

    // register indexes on the configuration port
    localparam logic [IdxW-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [IdxW-1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [IdxW-1:0] CFG_DBL_GAP    = 2'd2;

    // reset values of the thresholds
    localparam logic [ThrW-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [ThrW-1:0] LONG_PRESS_RST = 16'd700;
    localparam logic [ThrW-1:0] DBL_GAP_RST    = 16'd250;

    // event codes
    localparam logic [KindW-1:0] EV_SINGLE = 2'd0;
    localparam logic [KindW-1:0] EV_LONG   = 2'd1;
    localparam logic [KindW-1:0] EV_DOUBLE = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_DEBOUNCE    = 3'd1,
        PH_PRESSED     = 3'd2,
        PH_WAIT_UP     = 3'd3,
        PH_WAIT_SECOND = 3'd4
    } phase_t;

    typedef struct packed {
        logic             pin_low;
        logic [TimeW-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic [ThrW-1:0] debounce_time;
        logic [ThrW-1:0] long_press_time;
        logic [ThrW-1:0] double_click_gap;
    } thresholds_t;

    // handshake between the input register and the classifier
    typedef struct packed {
        logic valid;
        logic fire;
    } stage_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bpc_cfg_regs.sv -----
`default_nettype none

module bpc_cfg_regs (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [bpc_pkg::IdxW-1:0]  cfg_index,
    input  wire logic [bpc_pkg::ThrW-1:0]  cfg_data,
    output bpc_pkg::thresholds_t           thr
);
    import bpc_pkg::*;

    thresholds_t thr_reg;
    thresholds_t thr_next;

    // decode the register index, unknown indexes are dropped
    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE:   thr_next.debounce_time    = cfg_data;
                CFG_LONG_PRESS: thr_next.long_press_time  = cfg_data;
                CFG_DBL_GAP:    thr_next.double_click_gap = cfg_data;
                default:        thr_next = thr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.debounce_time    <= DEBOUNCE_RST;
            thr_reg.long_press_time  <= LONG_PRESS_RST;
            thr_reg.double_click_gap <= DBL_GAP_RST;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign thr = thr_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bpc_in_stage.sv -----
`default_nettype none

module bpc_in_stage (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      pin_low,
    input  wire logic [bpc_pkg::TimeW-1:0] now_ms,
    input  wire logic                      fire,
    output logic                           sample_valid,
    output bpc_pkg::sample_t               sample
);
    import bpc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    logic    accept;
    sample_t sample_reg;

    // hold off only while a sample sits here and cannot move on
    assign in_stall = valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (fire)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg.pin_low <= pin_low;
            sample_reg.now_ms  <= now_ms;
        end
    end

    assign sample_valid = valid_reg;
    assign sample       = sample_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bpc_classify.sv -----
`default_nettype none

module bpc_classify (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bpc_pkg::thresholds_t       thr,
    input  wire logic                       sample_valid,
    input  wire bpc_pkg::sample_t           sample,
    output bpc_pkg::stage_ctl_t             ctl,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [bpc_pkg::KindW-1:0]       event_kind
);
    import bpc_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [TimeW-1:0]   mark_reg;
    logic [TimeW-1:0]   mark_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [KindW-1:0]   kind_reg;
    logic [KindW-1:0]   kind_next;
    logic               emit;
    logic [KindW-1:0]   emit_kind;
    logic               fire;
    logic [TimeW-1:0]   elapsed;
    logic               past_debounce;
    logic               past_long;
    logic               past_gap;
    logic               under_gap;

    // a sample moves on when the result slot is free or being emptied
    assign fire = sample_valid && (!out_valid_reg || !out_stall);
    assign ctl.valid = sample_valid;
    assign ctl.fire  = fire;

    // wrapping elapsed time and threshold compares
    assign elapsed       = sample.now_ms - mark_reg;
    assign past_debounce = elapsed > {{(TimeW-ThrW){1'b0}}, thr.debounce_time};
    assign past_long     = elapsed > {{(TimeW-ThrW){1'b0}}, thr.long_press_time};
    assign past_gap      = elapsed > {{(TimeW-ThrW){1'b0}}, thr.double_click_gap};
    assign under_gap     = elapsed < {{(TimeW-ThrW){1'b0}}, thr.double_click_gap};

    // phase transitions and event decision
    always_comb
    begin
        phase_next = phase_reg;
        mark_next  = mark_reg;
        emit       = 1'b0;
        emit_kind  = EV_SINGLE;
        case (phase_reg)
            PH_DEBOUNCE:
            begin
                if (past_debounce)
                begin
                    if (sample.pin_low)
                    begin
                        phase_next = PH_PRESSED;
                        mark_next  = sample.now_ms;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_PRESSED:
            begin
                if (sample.pin_low)
                begin
                    if (past_long)
                    begin
                        emit       = 1'b1;
                        emit_kind  = EV_LONG;
                        phase_next = PH_WAIT_UP;
                    end
                end
                else if (under_gap)
                begin
                    phase_next = PH_WAIT_SECOND;
                    mark_next  = sample.now_ms;
                end
                else
                begin
                    emit       = 1'b1;
                    emit_kind  = EV_SINGLE;
                    phase_next = PH_IDLE;
                end
            end
            PH_WAIT_UP:
            begin
                if (!sample.pin_low)
                    phase_next = PH_IDLE;
            end
            PH_WAIT_SECOND:
            begin
                if (past_gap)
                begin
                    emit       = 1'b1;
                    emit_kind  = EV_SINGLE;
                    phase_next = PH_IDLE;
                end
                else if (sample.pin_low)
                begin
                    emit       = 1'b1;
                    emit_kind  = EV_DOUBLE;
                    phase_next = PH_WAIT_UP;
                end
            end
            default:
            begin
                // idle, and any stray code behaves as idle
                if (sample.pin_low)
                begin
                    phase_next = PH_DEBOUNCE;
                    mark_next  = sample.now_ms;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    // result register next value
    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (fire && emit)
        begin
            out_valid_next = 1'b1;
            kind_next      = emit_kind;
        end
    end

    // phase and mark update only when a transaction is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            mark_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg <= phase_next;
                mark_reg  <= mark_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/button_press_classifier.sv -----
`default_nettype none

// Push-button classifier: each input transaction is one poll of an active-low
// button (pin_low) with a free-running millisecond timestamp (now_ms), and the
// block reports single press (0), long press (1) or double click (2) on
// event_kind, at most one event per poll. Thresholds are written through
// cfg_we/cfg_index/cfg_data (0 debounce, 1 long press, 2 double-click gap,
// reset 50/700/250 ms); write them only while no poll is in flight. A poll
// is accepted every cycle unless in_stall is high; it is held in the input
// register until the classifier takes it, and its event is then registered
// on the output register. in_stall rises only while an event is held back by
// out_stall and another poll is already waiting behind it.
module button_press_classifier (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [bpc_pkg::IdxW-1:0]  cfg_index,
    input  wire logic [bpc_pkg::ThrW-1:0]  cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      pin_low,
    input  wire logic [bpc_pkg::TimeW-1:0] now_ms,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [bpc_pkg::KindW-1:0]      event_kind
);
    import bpc_pkg::*;

    thresholds_t thr;
    sample_t     sample;
    logic        sample_valid;
    stage_ctl_t  ctl;

    // threshold registers
    bpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thr       (thr)
    );

    // input register
    bpc_in_stage u_in (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pin_low      (pin_low),
        .now_ms       (now_ms),
        .fire         (ctl.fire),
        .sample_valid (sample_valid),
        .sample       (sample)
    );

    // phase machine and result register
    bpc_classify u_cls (
        .clk          (clk),
        .rst_n        (rst_n),
        .thr          (thr),
        .sample_valid (sample_valid),
        .sample       (sample),
        .ctl          (ctl),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/bpc_checker.sv -----
`default_nettype none

module bpc_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic [bpc_pkg::KindW-1:0] event_kind
);
    import bpc_pkg::*;

    // a held event stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_kind))
        else $error("event changed while stalled");

    // only defined event codes leave the block
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_kind == EV_SINGLE || event_kind == EV_LONG ||
                       event_kind == EV_DOUBLE))
        else $error("undefined event code");

    // input back-pressure only comes from a blocked output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // a fresh event must follow an accepted poll
    a_event_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("event without a preceding poll");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (.*);

`default_nettype wire

// ----- bench/button_press_classifier_tb.sv -----
`timescale 1ns / 100ps

module button_press_classifier_tb;

    import bpc_pkg::*;

    // register index outside the map, writes to it must be ignored
    localparam logic [IdxW-1:0] CFG_NONE = 2'd3;
    localparam int PHASE_POLLS   = 125;
    localparam int RANDOM_PHASES = 6;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 6;

    typedef enum logic {
        ROW_POLL,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t         op;
        logic              pin;
        logic [TimeW-1:0]  stamp;
        logic [IdxW-1:0]   idx;
        logic [ThrW-1:0]   val;
        logic              typed;
        logic [KindW-1:0]  kind;
    } plan_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [IdxW-1:0]   cfg_index = '0;
    logic [ThrW-1:0]   cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              pin_low = 1'b0;
    logic [TimeW-1:0]  now_ms = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [KindW-1:0]  event_kind;

    // classifier shadow state
    phase_t            phase_model = PH_IDLE;
    logic [TimeW-1:0]  mark_model = '0;
    thresholds_t       thr_model = '{DEBOUNCE_RST, LONG_PRESS_RST, DBL_GAP_RST};

    logic [KindW-1:0]  pending_events [$];
    plan_row_t         plan [$];
    logic [TimeW-1:0]  clock_ms = '0;
    int                poll_count = 0;
    int                mismatch_count = 0;
    int                idle_cycles = 0;
    int                stall_run = 0;
    bit                no_idle = 1'b0;
    bit                stall_now;

    button_press_classifier dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pin_low    (pin_low),
        .now_ms     (now_ms),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_kind (event_kind)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // advance the shadow state by one poll, returns 1 when an event is due
    function automatic logic classify_poll(input logic low, input logic [TimeW-1:0] stamp,
                                           output logic [KindW-1:0] kind);
        logic [TimeW-1:0] elapsed;
        logic             hit;
        elapsed = stamp - mark_model;
        hit = 1'b0;
        kind = EV_SINGLE;
        case (phase_model)
            PH_DEBOUNCE:
            begin
                if (elapsed > thr_model.debounce_time)
                begin
                    if (low)
                    begin
                        phase_model = PH_PRESSED;
                        mark_model = stamp;
                    end
                    else
                        phase_model = PH_IDLE;
                end
            end
            PH_PRESSED:
            begin
                if (low)
                begin
                    if (elapsed > thr_model.long_press_time)
                    begin
                        kind = EV_LONG;
                        hit = 1'b1;
                        phase_model = PH_WAIT_UP;
                    end
                end
                else if (elapsed < thr_model.double_click_gap)
                begin
                    phase_model = PH_WAIT_SECOND;
                    mark_model = stamp;
                end
                else
                begin
                    kind = EV_SINGLE;
                    hit = 1'b1;
                    phase_model = PH_IDLE;
                end
            end
            PH_WAIT_UP:
            begin
                if (!low)
                    phase_model = PH_IDLE;
            end
            PH_WAIT_SECOND:
            begin
                // gap timeout wins over a second press
                if (elapsed > thr_model.double_click_gap)
                begin
                    kind = EV_SINGLE;
                    hit = 1'b1;
                    phase_model = PH_IDLE;
                end
                else if (low)
                begin
                    kind = EV_DOUBLE;
                    hit = 1'b1;
                    phase_model = PH_WAIT_UP;
                end
            end
            default:
            begin
                if (low)
                begin
                    phase_model = PH_DEBOUNCE;
                    mark_model = stamp;
                end
                else
                    phase_model = PH_IDLE;
            end
        endcase
        return hit;
    endfunction

    function automatic plan_row_t poll_row(input logic pin, input logic [TimeW-1:0] stamp);
        plan_row_t r;
        r = '0;
        r.op = ROW_POLL;
        r.pin = pin;
        r.stamp = stamp;
        return r;
    endfunction

    function automatic plan_row_t event_row(input logic pin, input logic [TimeW-1:0] stamp,
                                            input logic [KindW-1:0] kind);
        plan_row_t r;
        r = poll_row(pin, stamp);
        r.typed = 1'b1;
        r.kind = kind;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(input logic [IdxW-1:0] idx, input logic [ThrW-1:0] val);
        plan_row_t r;
        r = '0;
        r.op = ROW_CFG;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    // mostly mid-range thresholds, sometimes the extremes
    function automatic logic [ThrW-1:0] pick_threshold();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r <= 4)
            return ThrW'($urandom_range(0, 300));
        return ThrW'($urandom_range(0, 2000));
    endfunction

    // a duration near one of the thresholds, or anywhere up to twice it
    function automatic int pick_span();
        int thr;
        int r;
        int span;
        r = $urandom_range(0, 2);
        thr = (r == 0) ? int'(thr_model.debounce_time) :
              (r == 1) ? int'(thr_model.long_press_time) : int'(thr_model.double_click_gap);
        if ($urandom_range(0, 1) == 1)
            span = thr + int'($urandom_range(0, 6)) - 3;
        else
            span = int'($urandom_range(0, 2 * thr + 2));
        return (span < 0) ? 0 : span;
    endfunction

    // one poll transaction, with an optional idle burst in front
    task automatic send_poll(input logic low, input logic [TimeW-1:0] stamp,
                             input logic typed, input logic [KindW-1:0] typed_kind);
        logic [KindW-1:0] kind;
        logic             hit;
        int               gap;
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 18);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        pin_low <= low;
        now_ms <= stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        hit = classify_poll(low, stamp, kind);
        if (typed)
            pending_events.push_back(typed_kind);
        else if (hit)
            pending_events.push_back(kind);
        poll_count++;
    endtask

    // stop sending and let every expected event and any quiet poll get out
    task automatic drain_events();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [ThrW-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DEBOUNCE:   thr_model.debounce_time = val;
            CFG_LONG_PRESS: thr_model.long_press_time = val;
            CFG_DBL_GAP:    thr_model.double_click_gap = val;
            default:        ;
        endcase
    endtask

    // level held for a duration, sampled by one to four polls
    task automatic hold_level(input logic level, input int dur);
        int n;
        int step;
        n = $urandom_range(1, 4);
        step = dur / n;
        for (int i = 0; i < n; i++)
        begin
            clock_ms += (i == n - 1) ? TimeW'(dur - step * (n - 1)) : TimeW'(step);
            send_poll(level, clock_ms, 1'b0, EV_SINGLE);
        end
    endtask

    // press and release segments timed around the thresholds
    task automatic press_gesture();
        int   segs;
        logic level;
        segs = $urandom_range(2, 6);
        level = 1'b1;
        send_poll(1'b1, clock_ms, 1'b0, EV_SINGLE);
        hold_level(1'b1, int'(thr_model.debounce_time) + pick_span());
        level = 1'b0;
        for (int s = 1; s < segs; s++)
        begin
            hold_level(level, pick_span());
            level = ~level;
        end
        hold_level(1'b0, pick_span());
    endtask

    // chatter with random levels, now and then a jump in the timestamp
    task automatic chatter();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                clock_ms = $urandom();
            else
                clock_ms += TimeW'($urandom_range(0, pick_span()));
            send_poll(1'($urandom_range(0, 1)), clock_ms, 1'b0, EV_SINGLE);
        end
    endtask

    // receiver stall bursts
    always @(negedge clk)
    begin
        if (no_idle)
            out_stall <= 1'b0;
        else if (stall_run > 0)
            stall_run--;
        else
        begin
            stall_now = ($urandom_range(0, 3) == 0);
            out_stall <= stall_now;
            stall_run = stall_now ? $urandom_range(0, 17) : $urandom_range(0, 29);
        end
    end

    // event checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: event_kind expected none actual %0d", $time, event_kind);
                mismatch_count++;
            end
            else if (event_kind !== pending_events[0])
            begin
                $display("%0t: event_kind expected %0d actual %0d", $time,
                         pending_events[0], event_kind);
                mismatch_count++;
                void'(pending_events.pop_front());
            end
            else
                void'(pending_events.pop_front());
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // stimulus
    initial
    begin
        int                phase_start;
        logic [ThrW-1:0]   deb;
        logic [ThrW-1:0]   lng;
        logic [ThrW-1:0]   gap;

        // long press, exactly at and just past each boundary
        plan.push_back(poll_row(1'b1, 32'd1000));
        plan.push_back(poll_row(1'b1, 32'd1050));
        plan.push_back(poll_row(1'b1, 32'd1051));
        plan.push_back(poll_row(1'b1, 32'd1751));
        plan.push_back(event_row(1'b1, 32'd1752, EV_LONG));
        plan.push_back(poll_row(1'b0, 32'd1800));
        // single press released right at the gap
        plan.push_back(poll_row(1'b1, 32'd2000));
        plan.push_back(poll_row(1'b1, 32'd2100));
        plan.push_back(event_row(1'b0, 32'd2350, EV_SINGLE));
        // double click, second press at the end of the window
        plan.push_back(poll_row(1'b1, 32'd3000));
        plan.push_back(poll_row(1'b1, 32'd3060));
        plan.push_back(poll_row(1'b0, 32'd3100));
        plan.push_back(event_row(1'b1, 32'd3350, EV_DOUBLE));
        plan.push_back(poll_row(1'b0, 32'd3400));
        // window runs out, single press
        plan.push_back(poll_row(1'b1, 32'd4000));
        plan.push_back(poll_row(1'b1, 32'd4051));
        plan.push_back(poll_row(1'b0, 32'd4100));
        plan.push_back(event_row(1'b0, 32'd4351, EV_SINGLE));
        // bounce, released while debouncing
        plan.push_back(poll_row(1'b1, 32'd5000));
        plan.push_back(poll_row(1'b0, 32'd5051));
        // timestamp wrap, then going backwards reads as a long hold
        plan.push_back(poll_row(1'b1, 32'hFFFF_FFF0));
        plan.push_back(poll_row(1'b1, 32'h0000_0030));
        plan.push_back(event_row(1'b1, 32'h0000_0020, EV_LONG));
        plan.push_back(poll_row(1'b0, 32'hFFFF_FFFF));
        // zero thresholds, no wait for a second press
        plan.push_back(cfg_row(CFG_NONE, 16'hFFFF));
        plan.push_back(cfg_row(CFG_DEBOUNCE, 16'h0000));
        plan.push_back(cfg_row(CFG_LONG_PRESS, 16'h0000));
        plan.push_back(cfg_row(CFG_DBL_GAP, 16'h0000));
        plan.push_back(poll_row(1'b1, 32'd100));
        plan.push_back(poll_row(1'b1, 32'd101));
        plan.push_back(event_row(1'b0, 32'd101, EV_SINGLE));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (plan[i])
        begin
            if (plan[i].op == ROW_CFG)
            begin
                drain_events();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
                send_poll(plan[i].pin, plan[i].stamp, plan[i].typed, plan[i].kind);
        end

        // random phases, each with its own thresholds
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_events();
            no_idle = (p == RANDOM_PHASES - 1);
            if (p == 0)
            begin
                deb = '0;
                lng = '0;
                gap = '0;
            end
            else if (p == 1)
            begin
                deb = '1;
                lng = '1;
                gap = '1;
            end
            else
            begin
                deb = pick_threshold();
                lng = pick_threshold();
                gap = pick_threshold();
            end
            write_reg(CFG_DEBOUNCE, deb);
            write_reg(CFG_LONG_PRESS, lng);
            write_reg(CFG_DBL_GAP, gap);
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_NONE, ThrW'($urandom()));
            if ($urandom_range(0, 3) == 0)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
            else
                clock_ms = $urandom();
            phase_start = poll_count;
            while (poll_count < phase_start + PHASE_POLLS)
            begin
                if (!no_idle && $urandom_range(0, 49) == 0)
                    drain_events();
                if ($urandom_range(0, 99) < 15)
                    chatter();
                else
                    press_gesture();
            end
        end

        // wind down
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
